// ===== src/prhd_pkg.sv =====
package prhd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  HDR_BYTE   = 8'h5a;
    localparam logic [7:0]  TRL_BYTE   = 8'ha5;
    localparam logic [20:0] POS_MAX    = 21'h1fffff;
    localparam logic [20:0] ENV_BYTES  = 21'd7;
    localparam logic [8:0]  FRAMES_MAX = 9'd256;
    localparam logic [4:0]  REGION_RST = 5'd31;
    localparam logic [7:0]  FRAME_RST  = 8'd255;
    localparam logic [10:0] ADDR_MAX   = 11'd1023;

    typedef enum logic {
        RK_HIT     = 1'b0,
        RK_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_SHORT   = 2'd1,
        ERR_FRAMING = 2'd2,
        ERR_LENGTH  = 2'd3
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [9:0]  base;
        logic [6:0]  map;
        logic [4:0]  region;
        logic [3:0]  enc;
        logic [7:0]  frame;
        logic [15:0] counter;
        logic [8:0]  frames;
        t_err        err;
    } t_job;

endpackage

// ===== src/prhd_front.sv =====
module prhd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_emit_hits,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_packet,
    output logic                 o_push,
    output prhd_pkg::t_job       o_job
);

    typedef enum logic [2:0] {
        TK_NONE,
        TK_SKIP,
        TK_SHORT,
        TK_LONG_LO,
        TK_LONG_MAP
    } t_tok;

    logic        r_emit_hits;
    logic [20:0] r_pos,       n_pos;
    logic [19:0] r_plen,      n_plen;
    logic [15:0] r_cnt,       n_cnt;
    logic        r_first_bad, n_first_bad;
    t_tok        r_tok,       n_tok;
    logic [5:0]  r_lead,      n_lead;
    logic [7:0]  r_addr_lo,   n_addr_lo;
    logic [4:0]  r_region,    n_region;
    logic [7:0]  r_frame,     n_frame;
    logic [8:0]  r_frames,    n_frames;

    always_comb begin
        n_pos       = r_pos;
        n_plen      = r_plen;
        n_cnt       = r_cnt;
        n_first_bad = r_first_bad;
        n_tok       = r_tok;
        n_lead      = r_lead;
        n_addr_lo   = r_addr_lo;
        n_region    = r_region;
        n_frame     = r_frame;
        n_frames    = r_frames;
        o_push      = 1'b0;
        o_job       = '0;
        o_job.kind    = prhd_pkg::RK_HIT;
        o_job.err     = prhd_pkg::ERR_OK;
        o_job.region  = r_region;
        o_job.enc     = r_lead[5:2];
        o_job.frame   = r_frame;
        o_job.counter = r_cnt;
        o_job.frames  = r_frames;

        if (i_accept) begin
            if (i_end_of_packet) begin
                o_push       = 1'b1;
                o_job.kind   = prhd_pkg::RK_SUMMARY;
                o_job.region = '0;
                o_job.enc    = '0;
                o_job.frame  = '0;
                if (r_pos < prhd_pkg::ENV_BYTES) begin
                    o_job.err = prhd_pkg::ERR_SHORT;
                end else if (r_first_bad || i_data_byte != prhd_pkg::TRL_BYTE) begin
                    o_job.err = prhd_pkg::ERR_FRAMING;
                end else if (({1'b0, r_plen} + prhd_pkg::ENV_BYTES) != r_pos) begin
                    o_job.err = prhd_pkg::ERR_LENGTH;
                end else begin
                    o_job.err = prhd_pkg::ERR_OK;
                end
                n_pos       = '0;
                n_plen      = '0;
                n_cnt       = '0;
                n_first_bad = 1'b0;
                n_tok       = TK_NONE;
                n_lead      = '0;
                n_addr_lo   = '0;
                n_region    = prhd_pkg::REGION_RST;
                n_frame     = prhd_pkg::FRAME_RST;
                n_frames    = '0;
            end else begin
                if (r_pos != prhd_pkg::POS_MAX) begin
                    n_pos = r_pos + 21'd1;
                end
                case (r_pos)
                    21'd0: n_first_bad = (i_data_byte != prhd_pkg::HDR_BYTE);
                    21'd1: ;
                    21'd2: n_plen = {i_data_byte[3:0], 16'h0000};
                    21'd3: n_plen = r_plen | {4'h0, i_data_byte, 8'h00};
                    21'd4: n_plen = r_plen | {12'h000, i_data_byte};
                    21'd5: n_cnt  = {i_data_byte, 8'h00};
                    21'd6: n_cnt  = r_cnt | {8'h00, i_data_byte};
                    default: begin
                        unique case (r_tok) inside
                            TK_NONE: begin
                                if (i_data_byte[7]) begin
                                    if (i_data_byte[6] && !i_data_byte[5]) begin
                                        n_region = i_data_byte[4:0];
                                    end else if (i_data_byte[5] && !i_data_byte[4]) begin
                                        n_frame = r_frame + 8'd1;
                                        if (r_frames != prhd_pkg::FRAMES_MAX) begin
                                            n_frames = r_frames + 9'd1;
                                        end
                                        n_tok = TK_SKIP;
                                    end
                                end else begin
                                    n_lead = i_data_byte[5:0];
                                    n_tok  = i_data_byte[6] ? TK_SHORT : TK_LONG_LO;
                                end
                            end
                            TK_SKIP: n_tok = TK_NONE;
                            TK_LONG_LO: begin
                                n_addr_lo = i_data_byte;
                                n_tok     = TK_LONG_MAP;
                            end
                            TK_SHORT, TK_LONG_MAP: begin
                                o_push     = r_emit_hits;
                                o_job.base = {r_lead[1:0],
                                              (r_tok == TK_SHORT) ? i_data_byte : r_addr_lo};
                                o_job.map  = (r_tok == TK_LONG_MAP) ? i_data_byte[6:0] : 7'h00;
                                n_tok      = TK_NONE;
                            end
                            default: n_tok = TK_NONE;
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_hits <= 1'b1;
            r_pos       <= '0;
            r_plen      <= '0;
            r_cnt       <= '0;
            r_first_bad <= 1'b0;
            r_tok       <= TK_NONE;
            r_lead      <= '0;
            r_addr_lo   <= '0;
            r_region    <= prhd_pkg::REGION_RST;
            r_frame     <= prhd_pkg::FRAME_RST;
            r_frames    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_emit_hits <= i_cfg_emit_hits;
            end
            r_pos       <= n_pos;
            r_plen      <= n_plen;
            r_cnt       <= n_cnt;
            r_first_bad <= n_first_bad;
            r_tok       <= n_tok;
            r_lead      <= n_lead;
            r_addr_lo   <= n_addr_lo;
            r_region    <= n_region;
            r_frame     <= n_frame;
            r_frames    <= n_frames;
        end
    end

endmodule

// ===== src/prhd_queue.sv =====
module prhd_queue #(
    parameter int DEPTH = prhd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  prhd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output prhd_pkg::t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    prhd_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== src/prhd_back.sv =====
module prhd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  prhd_pkg::t_job i_head,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic           o_result_kind,
    output logic [9:0]     o_hit_column,
    output logic [8:0]     o_hit_row,
    output logic [7:0]     o_hit_frame,
    output logic [15:0]    o_event_counter,
    output logic [8:0]     o_frame_count,
    output logic [1:0]     o_error_code,
    output logic           o_last_result
);

    prhd_pkg::t_job r_job;
    logic [7:0]     r_mask;
    logic           r_out_valid;
    logic           r_kind;
    logic [9:0]     r_col;
    logic [8:0]     r_row;
    logic [7:0]     r_frame;
    logic [15:0]    r_cnt;
    logic [8:0]     r_frames;
    logic [1:0]     r_err;
    logic           r_last;

    logic [2:0]     sel;
    logic [7:0]     rest;
    logic [7:0]     load_mask;
    logic [9:0]     addr;
    logic           advance;
    logic           load;

    always_comb begin
        sel = '0;
        for (int i = 7; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = 3'(i);
            end
        end
        rest = r_mask & ~(8'h01 << sel);
        addr = r_job.base + {7'h00, sel};
    end

    always_comb begin
        load_mask = 8'h01;
        if (i_head.kind == prhd_pkg::RK_HIT) begin
            for (int i = 1; i <= 7; i++) begin
                load_mask[i] = i_head.map[i-1] &&
                               (({1'b0, i_head.base} + 11'(i)) <= prhd_pkg::ADDR_MAX);
            end
        end
    end

    assign advance = (r_mask != '0) && (!r_out_valid || !i_out_stall);
    assign load    = !i_empty && ((r_mask == '0) || (advance && rest == '0));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mask <= load_mask;
            end else if (advance) begin
                r_mask <= rest;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
        end
        if (advance) begin
            r_kind   <= r_job.kind;
            r_cnt    <= r_job.counter;
            r_frames <= r_job.frames;
            r_err    <= r_job.err;
            r_last   <= (rest == '0);
            if (r_job.kind == prhd_pkg::RK_SUMMARY) begin
                r_col   <= '0;
                r_row   <= '0;
                r_frame <= '0;
            end else begin
                r_col   <= {r_job.region, r_job.enc, addr[0] == addr[1]};
                r_row   <= addr[9:1];
                r_frame <= r_job.frame;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_hit_column    = r_col;
    assign o_hit_row       = r_row;
    assign o_hit_frame     = r_frame;
    assign o_event_counter = r_cnt;
    assign o_frame_count   = r_frames;
    assign o_error_code    = r_err;
    assign o_last_result   = r_last;

endmodule

// ===== src/pixel_readout_hit_decoder_unit.sv =====
// Pixel readout hit decoder.
// Input channel (i_in_valid / o_in_stall) carries one packet byte per transfer,
// with i_end_of_packet on the final byte. Envelope: 0x5a, length word, event
// counter, payload tokens, 0xa5.
// Output channel (o_out_valid / i_out_stall) carries pixel hits and one
// end-of-packet summary per packet; o_last_result marks the last result of a
// byte. A data-long token yields up to eight hits, one per unstalled cycle.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// emit_hits; write it only while the block is idle.
// Throughput: one byte per cycle while the job queue has room; one result per
// cycle on the output unless stalled, so the back end's single result port
// sets the rate for bitmap runs. Results pass queue, job and output registers.
// The job queue (QUEUE_DEPTH entries) absorbs bursts; when full, o_in_stall
// rises. When the receiver stalls, the output register holds its result and
// the queue fills behind it.
// Reset (synchronous, active low) clears the packet state, empties the queue
// and sets emit_hits to 1.
module pixel_readout_hit_decoder_unit #(
    parameter int QUEUE_DEPTH = prhd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_emit_hits,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [9:0]  o_hit_column,
    output logic [8:0]  o_hit_row,
    output logic [7:0]  o_hit_frame,
    output logic [15:0] o_event_counter,
    output logic [8:0]  o_frame_count,
    output logic [1:0]  o_error_code,
    output logic        o_last_result
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    prhd_pkg::t_job job;
    prhd_pkg::t_job head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    prhd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_emit_hits (i_cfg_emit_hits),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_push          (push),
        .o_job           (job)
    );

    prhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    prhd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (head),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_hit_column    (o_hit_column),
        .o_hit_row       (o_hit_row),
        .o_hit_frame     (o_hit_frame),
        .o_event_counter (o_event_counter),
        .o_frame_count   (o_frame_count),
        .o_error_code    (o_error_code),
        .o_last_result   (o_last_result)
    );

endmodule

// ===== src/prhd_checker.sv =====
module prhd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_result_kind,
    input logic [9:0]  o_hit_column,
    input logic [8:0]  o_hit_row,
    input logic [7:0]  o_hit_frame,
    input logic [8:0]  o_frame_count,
    input logic [1:0]  o_error_code,
    input logic        o_last_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit_column)
            && $stable(o_hit_row) && $stable(o_result_kind) && $stable(o_last_result))
        else $error("stalled result changed");

    a_summary_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_last_result && o_hit_column == 10'd0
            && o_hit_row == 9'd0 && o_hit_frame == 8'd0)
        else $error("malformed summary");

    a_hit_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind |-> o_error_code == 2'd0)
        else $error("hit carries an error code");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_count <= 9'd256)
        else $error("frame count out of range");

endmodule

bind pixel_readout_hit_decoder_unit prhd_checker u_prhd_checker (.*);

// ===== bench/pixel_readout_hit_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
module pixel_readout_hit_decoder_unit_tb;

    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_SKIP,
        TOK_SHORT,
        TOK_LONG
    } t_tok;

    typedef struct packed {
        prhd_pkg::t_kind kind;
        logic [9:0]      column;
        logic [8:0]      row;
        logic [7:0]      frame;
        logic [15:0]     counter;
        logic [8:0]      frames;
        prhd_pkg::t_err  err;
        logic            last;
    } t_decoded;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 190;
    localparam int SETTLE_CYCLES = prhd_pkg::QUEUE_DEPTH + 8;

    localparam logic [7:0] LEAD_BUSY    = 8'hf0;
    localparam logic [7:0] LEAD_EMPTY   = 8'he0;
    localparam logic [7:0] LEAD_REGION  = 8'hc0;
    localparam logic [7:0] LEAD_TRAILER = 8'hb0;
    localparam logic [7:0] LEAD_CHIP    = 8'ha0;
    localparam logic [7:0] LEAD_UNDEF   = 8'h80;
    localparam logic [7:0] LEAD_DSHORT  = 8'h40;
    localparam logic [7:0] LEAD_DLONG   = 8'h00;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_emit_hits = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_packet = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_result_kind;
    logic [9:0]  o_hit_column;
    logic [8:0]  o_hit_row;
    logic [7:0]  o_hit_frame;
    logic [15:0] o_event_counter;
    logic [8:0]  o_frame_count;
    logic [1:0]  o_error_code;
    logic        o_last_result;

    logic        emit_on;
    logic [20:0] pkt_pos;
    logic [19:0] pkt_len;
    logic [15:0] pkt_evc;
    logic        hdr_bad;
    t_tok        tok_kind;
    logic [1:0]  tok_left;
    logic [7:0]  tok_lead;
    logic [7:0]  tok_addr_lo;
    logic [4:0]  cur_region;
    logic [7:0]  cur_frame;
    logic [8:0]  frame_tally;

    t_decoded    byte_out[$];
    t_decoded    decoded_q[$];
    t_decoded    head;
    logic [7:0]  payload_q[$];

    int          mismatches = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    bit          src_idle = 1'b1;
    bit          snk_idle = 1'b1;

    pixel_readout_hit_decoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_emit_hits (i_cfg_emit_hits),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_hit_column    (o_hit_column),
        .o_hit_row       (o_hit_row),
        .o_hit_frame     (o_hit_frame),
        .o_event_counter (o_event_counter),
        .o_frame_count   (o_frame_count),
        .o_error_code    (o_error_code),
        .o_last_result   (o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function void clear_packet();
        pkt_pos     = '0;
        pkt_len     = '0;
        pkt_evc     = '0;
        hdr_bad     = 1'b0;
        tok_kind    = TOK_NONE;
        tok_left    = '0;
        tok_lead    = '0;
        tok_addr_lo = '0;
        cur_region  = prhd_pkg::REGION_RST;
        cur_frame   = prhd_pkg::FRAME_RST;
        frame_tally = '0;
    endfunction

    function void queue_result(input t_decoded r);
        byte_out = {byte_out, r};
    endfunction

    function void queue_payload(input logic [7:0] b);
        payload_q = {payload_q, b};
    endfunction

    function void add_hit(input logic [10:0] addr);
        t_decoded r;
        if (addr <= prhd_pkg::ADDR_MAX) begin
            r = '0;
            r.kind    = prhd_pkg::RK_HIT;
            r.column  = {cur_region, 5'd0} + {5'd0, tok_lead[5:2], 1'b0}
                        + {9'd0, addr[0] == addr[1]};
            r.row     = addr[9:1];
            r.frame   = cur_frame;
            r.counter = pkt_evc;
            r.frames  = frame_tally;
            r.err     = prhd_pkg::ERR_OK;
            queue_result(r);
        end
    endfunction

    function void advance_frame();
        cur_frame = cur_frame + 8'd1;
        if (frame_tally < prhd_pkg::FRAMES_MAX) frame_tally = frame_tally + 9'd1;
    endfunction

    function void decode_payload(input logic [7:0] b);
        logic [9:0] base;
        if (tok_kind == TOK_NONE) begin
            if (b[7:6] == 2'b11) begin
                if (!b[5]) begin
                    cur_region = b[4:0];
                end else if (!b[4]) begin
                    advance_frame();
                    tok_kind = TOK_SKIP;
                    tok_left = 2'd1;
                end
            end else if (b[7]) begin
                if (b[5:4] == 2'b10) begin
                    advance_frame();
                    tok_kind = TOK_SKIP;
                    tok_left = 2'd1;
                end
            end else begin
                tok_lead = b;
                tok_kind = b[6] ? TOK_SHORT : TOK_LONG;
                tok_left = b[6] ? 2'd1 : 2'd2;
            end
        end else if (tok_kind == TOK_SKIP) begin
            tok_kind = TOK_NONE;
            tok_left = 2'd0;
        end else if (tok_kind == TOK_LONG && tok_left == 2'd2) begin
            tok_addr_lo = b;
            tok_left    = 2'd1;
        end else begin
            base = {tok_lead[1:0], (tok_kind == TOK_SHORT) ? b : tok_addr_lo};
            if (emit_on) begin
                add_hit({1'b0, base});
                if (tok_kind == TOK_LONG) begin
                    for (int i = 1; i <= 7; i++) begin
                        if (b[i-1]) add_hit({1'b0, base} + 11'(i));
                    end
                end
            end
            tok_kind = TOK_NONE;
            tok_left = 2'd0;
        end
    endfunction

    function void decode_byte(input logic [7:0] b, input logic eop);
        t_decoded r;
        int       size;
        byte_out.delete();
        if (eop) begin
            size      = int'(pkt_pos) + 1;
            r         = '0;
            r.kind    = prhd_pkg::RK_SUMMARY;
            r.counter = pkt_evc;
            r.frames  = frame_tally;
            if (size < 8) begin
                r.err = prhd_pkg::ERR_SHORT;
            end else if (hdr_bad || b != prhd_pkg::TRL_BYTE || pkt_pos == 0) begin
                r.err = prhd_pkg::ERR_FRAMING;
            end else if (int'(pkt_len) + 8 != size) begin
                r.err = prhd_pkg::ERR_LENGTH;
            end else begin
                r.err = prhd_pkg::ERR_OK;
            end
            queue_result(r);
            clear_packet();
        end else begin
            case (pkt_pos)
                21'd0: hdr_bad = (b != prhd_pkg::HDR_BYTE);
                21'd1: begin end
                21'd2: pkt_len = {b[3:0], 16'h0000};
                21'd3: pkt_len[15:8] = b;
                21'd4: pkt_len[7:0] = b;
                21'd5: pkt_evc = {b, 8'h00};
                21'd6: pkt_evc[7:0] = b;
                default: decode_payload(b);
            endcase
            if (pkt_pos < prhd_pkg::POS_MAX) pkt_pos = pkt_pos + 21'd1;
        end
        if (byte_out.size() != 0) begin
            r = byte_out.pop_back();
            r.last = 1'b1;
            queue_result(r);
        end
        decoded_q = {decoded_q, byte_out};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eop);
        while (src_idle && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_packet <= eop;
        do @(posedge i_clk); while (o_in_stall);
        decode_byte(b, eop);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [15:0] evc, input int len_adj,
                               input bit bad_hdr, input bit bad_trl);
        logic [19:0] len;
        logic [7:0]  hdr;
        logic [7:0]  trl;
        len = 20'(payload_q.size() + len_adj);
        hdr = bad_hdr ? (prhd_pkg::HDR_BYTE ^ 8'($urandom_range(255, 1)))
                      : prhd_pkg::HDR_BYTE;
        trl = bad_trl ? (prhd_pkg::TRL_BYTE ^ 8'($urandom_range(255, 1)))
                      : prhd_pkg::TRL_BYTE;
        send_byte(hdr, 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte({4'($urandom), len[19:16]}, 1'b0);
        send_byte(len[15:8], 1'b0);
        send_byte(len[7:0], 1'b0);
        send_byte(evc[15:8], 1'b0);
        send_byte(evc[7:0], 1'b0);
        foreach (payload_q[k]) send_byte(payload_q[k], 1'b0);
        send_byte(trl, 1'b1);
        payload_q.delete();
    endtask

    task automatic send_fragment(input int n);
        for (int k = 0; k < n; k++) send_byte(8'($urandom), k == n - 1);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_emit(input logic v);
        settle();
        i_cfg_valid     <= 1'b1;
        i_cfg_emit_hits <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        emit_on = v;
    endtask

    function void add_random_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            queue_payload(LEAD_DSHORT | 8'($urandom_range(63)));
            queue_payload(8'($urandom));
        end else if (pick < 55) begin
            queue_payload(LEAD_DLONG | 8'($urandom_range(63)));
            queue_payload(8'($urandom));
            queue_payload(8'($urandom));
        end else if (pick < 70) begin
            queue_payload(LEAD_REGION | 8'($urandom_range(31)));
        end else if (pick < 80) begin
            queue_payload(LEAD_CHIP | 8'($urandom_range(15)));
            queue_payload(8'($urandom));
        end else if (pick < 88) begin
            queue_payload(LEAD_EMPTY | 8'($urandom_range(15)));
            queue_payload(8'($urandom));
        end else if (pick < 92) begin
            queue_payload(LEAD_BUSY | 8'($urandom_range(15)));
        end else if (pick < 96) begin
            queue_payload(LEAD_TRAILER | 8'($urandom_range(15)));
        end else begin
            queue_payload(LEAD_UNDEF | 8'($urandom_range(31)));
        end
    endfunction

    task automatic test_envelope_errors();
        send_fragment(1);
        send_fragment(7);
        send_packet(16'h0000, 0, 1'b0, 1'b0);
        send_packet(16'hffff, 0, 1'b1, 1'b0);
        send_packet(16'h1234, 0, 1'b0, 1'b1);
        send_packet(16'h8001, -1, 1'b0, 1'b0);
        payload_q = '{LEAD_DSHORT, 8'h10};
        send_packet(16'h00ff, 3, 1'b0, 1'b0);
        payload_q = '{LEAD_DSHORT | 8'h01, 8'h22};
        send_packet(16'h7f00, -2, 1'b0, 1'b0);
    endtask

    task automatic test_token_kinds();
        payload_q = '{LEAD_REGION, LEAD_DSHORT, 8'h00, LEAD_DSHORT | 8'h3f, 8'hff,
                      LEAD_REGION | 8'h1f, LEAD_DLONG | 8'h3f, 8'hf8, 8'hff,
                      LEAD_DLONG | 8'h03, 8'hff, 8'h7f, LEAD_DLONG, 8'h00, 8'h80,
                      LEAD_BUSY | 8'h05, LEAD_EMPTY | 8'h02, 8'h5a,
                      LEAD_TRAILER | 8'h07, LEAD_CHIP | 8'h01, 8'hff,
                      LEAD_UNDEF | 8'h0c, LEAD_UNDEF | 8'h1f, LEAD_DLONG | 8'h2a};
        send_packet(16'hbeef, 0, 1'b0, 1'b0);
        payload_q = '{LEAD_DSHORT | 8'h11, 8'h33, LEAD_EMPTY};
        send_packet(16'h0042, 0, 1'b0, 1'b0);
    endtask

    task automatic test_emit_off();
        write_emit(1'b0);
        payload_q = '{LEAD_CHIP, 8'h00, LEAD_REGION | 8'h05, LEAD_DSHORT | 8'h2b, 8'h9c,
                      LEAD_DLONG | 8'h16, 8'h40, 8'h7f, LEAD_EMPTY | 8'h0f, 8'h00};
        send_packet(16'hc3c3, 0, 1'b0, 1'b0);
        write_emit(1'b1);
    endtask

    task automatic test_frame_wrap();
        repeat (12) begin
            queue_payload(LEAD_CHIP | 8'($urandom_range(15)));
            queue_payload(8'($urandom));
        end
        repeat (12) begin
            queue_payload(LEAD_EMPTY | 8'($urandom_range(15)));
            queue_payload(8'($urandom));
        end
        queue_payload(LEAD_DSHORT | 8'h15);
        queue_payload(8'h42);
        send_packet(16'h0101, 0, 1'b0, 1'b0);
    endtask

    task automatic test_bitmap_burst();
        settle();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        repeat (6) begin
            queue_payload(LEAD_DLONG | 8'($urandom_range(63)));
            queue_payload(8'($urandom));
            queue_payload(8'h7f | 8'($urandom));
        end
        repeat (4) begin
            queue_payload(LEAD_DSHORT | 8'($urandom_range(63)));
            queue_payload(8'($urandom));
        end
        send_packet(16'($urandom), 0, 1'b0, 1'b0);
        wait_results();
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    task automatic test_random_packets();
        int start;
        int pkt;
        int shape;
        int phase;
        int cur_phase;
        start     = bytes_sent;
        pkt       = 0;
        cur_phase = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            phase = (bytes_sent - start) * 3 / RANDOM_BYTES;
            if (phase != cur_phase) begin
                write_emit(phase != 1);
                cur_phase = phase;
            end
            if (pkt % 12 == 11) wait_results();
            repeat ($urandom_range(8, 1)) add_random_token();
            shape = $urandom_range(99);
            if (shape < 80) begin
                send_packet(16'($urandom), 0, 1'b0, 1'b0);
            end else if (shape < 84) begin
                send_packet(16'($urandom), 0, 1'b1, 1'b0);
            end else if (shape < 88) begin
                send_packet(16'($urandom), 0, 1'b0, 1'b1);
            end else if (shape < 93) begin
                send_packet(16'($urandom),
                            ($urandom_range(1) ? 1 : -1) * int'($urandom_range(3, 1)),
                            1'b0, 1'b0);
            end else if (shape < 96) begin
                // cut the last token short with the packet end
                if ($urandom_range(1)) begin
                    queue_payload(LEAD_DLONG | 8'($urandom_range(63)));
                    if ($urandom_range(1)) queue_payload(8'($urandom));
                end else begin
                    queue_payload(LEAD_EMPTY | 8'($urandom_range(15)));
                end
                send_packet(16'($urandom), 0, 1'b0, 1'b0);
            end else begin
                payload_q.delete();
                send_fragment($urandom_range(7, 1));
            end
            pkt++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= snk_idle && ($urandom_range(99) < 21);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected transfer, result_kind", int'(o_result_kind), -1);
            end else begin
                head = decoded_q.pop_front();
                if (o_result_kind !== head.kind)
                    report_mismatch("result_kind", int'(o_result_kind), int'(head.kind));
                if (o_hit_column !== head.column)
                    report_mismatch("hit_column", int'(o_hit_column), int'(head.column));
                if (o_hit_row !== head.row)
                    report_mismatch("hit_row", int'(o_hit_row), int'(head.row));
                if (o_hit_frame !== head.frame)
                    report_mismatch("hit_frame", int'(o_hit_frame), int'(head.frame));
                if (o_event_counter !== head.counter)
                    report_mismatch("event_counter", int'(o_event_counter),
                                    int'(head.counter));
                if (o_frame_count !== head.frames)
                    report_mismatch("frame_count", int'(o_frame_count), int'(head.frames));
                if (o_error_code !== head.err)
                    report_mismatch("error_code", int'(o_error_code), int'(head.err));
                if (o_last_result !== head.last)
                    report_mismatch("last_result", int'(o_last_result), int'(head.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        clear_packet();
        emit_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_envelope_errors();
        test_token_kinds();
        test_emit_off();
        test_frame_wrap();
        test_bitmap_burst();
        test_random_packets();
        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
